// ===== rtl/core/sgfa_pkg.sv =====
// sgfa_pkg: shared widths, codes and controller/datapath interface structs
// for the softened gravity force accumulator; no dependencies
package sgfa_pkg;

    // field widths
    localparam int ACT_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int POS_W     = 24;
    localparam int MASS_W    = 16;
    localparam int GAIN_W    = 16;
    localparam int MCNT_W    = 7;
    localparam int FCNT_W    = 5;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // arithmetic widths
    localparam int MAG_W   = POS_W + 1;        // |dx| below 2^24
    localparam int SQ2_W   = 2 * MAG_W;        // dx*dx
    localparam int R2_W    = SQ2_W;            // dx*dx + dy*dy
    localparam int GM1_W   = GAIN_W + MASS_W;  // G*ma
    localparam int GMM_W   = GM1_W + MASS_W;   // G*ma*mb
    localparam int NUM_W   = 64;               // divider dividend
    localparam int Q_W     = 42;               // pull coefficient
    localparam int QH_W    = Q_W / 2;          // coefficient half for the term multiply
    localparam int PP_W    = QH_W + MAG_W;
    localparam int PROD_W  = PP_W + QH_W;
    localparam int SQV_W   = 23;               // near-field r2 fits here
    localparam int SQR_W   = SQV_W + 1;
    localparam int SQS_W   = 12;               // isqrt of near-field r2
    localparam int DCNT_W  = 6;                // 64 quotient bits

    // soft-zone threshold (100 in Q.16) and near-field divisor (1000 * 256)
    localparam logic [R2_W-1:0] SOFT_R2  = R2_W'(6553600);
    localparam logic [R2_W-1:0] SOFT_DIV = R2_W'(256000);
    localparam logic [SQV_W-1:0] SQ_BIT_INIT = SQV_W'(1) << (SQV_W - 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = '1;

    // request action codes
    localparam logic [ACT_W-1:0] ACT_LOAD_MOVING = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_FIXED  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_COUNT  = 2'd2;

    typedef struct packed {
        logic wr_moving;
        logic wr_fixed;
        logic start;
        logic rd_row;
        logic ld_row;
        logic rd_fix;
        logic ld_fix;
        logic rd_mov;
        logic ld_mov;
        logic p_diff;
        logic p_sq;
        logic p_r2;
        logic div_far;
        logic sqrt_init;
        logic sqrt_step;
        logic near_mul;
        logic div_near;
        logic div_step;
        logic t_lo;
        logic t_hi;
        logic t_term;
        logic acc_fix;
        logic acc_pair;
        logic row_wr;
        logic rd_out;
        logic out_load;
        logic out_last;
    } t_cmd;

    typedef struct packed {
        logic men_i;
        logic men_j;
        logic fen_j;
        logic far;
        logic sqrt_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/softened_gravity_force_accumulator.sv =====
// softened_gravity_force_accumulator: top level, configuration registers and
// the sequencer/datapath pair; depends on sgfa_pkg, sgfa_ctrl, sgfa_dp
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  request  | in        | i_valid / o_stall     | action, slot, body_x/y, mass, enabled
//  result   | out       | o_valid / i_stall     | body_index, force_x/y, last
//  config   | in        | i_cfg_valid/o_cfg_ready | cfg_index, cfg_data
//
// a load request never stalls the request port, which is stalled during a compute.
// a compute walks every active fixed partner and every later active moving
// partner of each active moving row; each pull runs the 64-step restoring
// divider, and in the near zone the 12-step square root before it.
// results then leave one by one in slot order, each held while the output side stalls.
// synchronous active-low reset clears the enable bits, counters and valid flags.
module softened_gravity_force_accumulator #(
    parameter int MAX_MOVING  = 64,
    parameter int MAX_FIXED   = 16,
    parameter int FORCE_WIDTH = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sgfa_pkg::ACT_W-1:0]          i_action,
    input  logic [sgfa_pkg::SLOT_W-1:0]         i_slot,
    input  logic signed [sgfa_pkg::POS_W-1:0]   i_body_x,
    input  logic signed [sgfa_pkg::POS_W-1:0]   i_body_y,
    input  logic [sgfa_pkg::MASS_W-1:0]         i_mass,
    input  logic                                i_enabled,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sgfa_pkg::IDX_W-1:0]          o_body_index,
    output logic signed [FORCE_WIDTH-1:0]       o_force_x,
    output logic signed [FORCE_WIDTH-1:0]       o_force_y,
    output logic                                o_last,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sgfa_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import sgfa_pkg::*;

    localparam int MC = $clog2(MAX_MOVING + 1);
    localparam int FC = $clog2(MAX_FIXED + 1);

    logic [GAIN_W-1:0] r_gravity_gain;
    logic [MCNT_W-1:0] r_moving_count;
    logic [FCNT_W-1:0] r_fixed_count;
    logic              cfg_wr;

    t_cmd          cmd;
    t_sts          sts;
    logic [MC-1:0] idx_i, idx_jm;
    logic [FC-1:0] idx_jf;

    // configuration is always accepted; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity_gain <= GAIN_W'(10);
            r_moving_count <= '0;
            r_fixed_count  <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_GRAVITY_GAIN: r_gravity_gain <= i_cfg_data;
                CFG_MOVING_COUNT: r_moving_count <= i_cfg_data[MCNT_W-1:0];
                CFG_FIXED_COUNT:  r_fixed_count  <= i_cfg_data[FCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: pair walk over the tables, pull step order, result output
    sgfa_ctrl #(
        .MAX_MOVING (MAX_MOVING),
        .MAX_FIXED  (MAX_FIXED)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_action       (i_action),
        .o_stall        (o_stall),
        .i_moving_count (r_moving_count),
        .i_fixed_count  (r_fixed_count),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_i            (idx_i),
        .o_jm           (idx_jm),
        .o_jf           (idx_jf)
    );

    // datapath: tables, accumulators, pull arithmetic, output register
    sgfa_dp #(
        .MAX_MOVING  (MAX_MOVING),
        .MAX_FIXED   (MAX_FIXED),
        .FORCE_WIDTH (FORCE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_i            (idx_i),
        .i_jm           (idx_jm),
        .i_jf           (idx_jf),
        .i_gravity_gain (r_gravity_gain),
        .i_slot         (i_slot),
        .i_body_x       (i_body_x),
        .i_body_y       (i_body_y),
        .i_mass         (i_mass),
        .i_enabled      (i_enabled),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_body_index   (o_body_index),
        .o_force_x      (o_force_x),
        .o_force_y      (o_force_y),
        .o_last         (o_last)
    );
endmodule

// ===== rtl/core/sgfa_ram.sv =====
// sgfa_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module sgfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/core/sgfa_ctrl.sv =====
// sgfa_ctrl: sequencer for loads, the pair walk, the pull steps and result output
// depends on sgfa_pkg
module sgfa_ctrl #(
    parameter int MAX_MOVING = 64,
    parameter int MAX_FIXED  = 16,
    localparam int MC = $clog2(MAX_MOVING + 1),
    localparam int FC = $clog2(MAX_FIXED + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [sgfa_pkg::ACT_W-1:0]   i_action,
    output logic                         o_stall,
    input  logic [sgfa_pkg::MCNT_W-1:0]  i_moving_count,
    input  logic [sgfa_pkg::FCNT_W-1:0]  i_fixed_count,
    input  sgfa_pkg::t_sts               i_sts,
    output sgfa_pkg::t_cmd               o_cmd,
    output logic [MC-1:0]                o_i,
    output logic [MC-1:0]                o_jm,
    output logic [FC-1:0]                o_jf
);
    import sgfa_pkg::*;

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_ROW     = 22'h000002,
        S_ROW_LD  = 22'h000004,
        S_FIX     = 22'h000008,
        S_FIX_LD  = 22'h000010,
        S_MOV     = 22'h000020,
        S_MOV_LD  = 22'h000040,
        S_P_DIFF  = 22'h000080,
        S_P_SQ    = 22'h000100,
        S_P_R2    = 22'h000200,
        S_P_SEL   = 22'h000400,
        S_P_SQRT  = 22'h000800,
        S_P_NMUL  = 22'h001000,
        S_P_NDIV  = 22'h002000,
        S_P_DIV   = 22'h004000,
        S_P_TLO   = 22'h008000,
        S_P_THI   = 22'h010000,
        S_P_TERM  = 22'h020000,
        S_P_ACC   = 22'h040000,
        S_ROW_END = 22'h080000,
        S_OUT_RD  = 22'h100000,
        S_OUT_WR  = 22'h200000
    } t_state;

    t_state         r_state, n_state;
    logic [MC-1:0]  r_i, n_i, r_jm, n_jm, r_nm, n_nm;
    logic [FC-1:0]  r_jf, n_jf, r_nf, n_nf;
    logic           r_pair, n_pair;
    logic           accept;
    logic [MC-1:0]  nm_clamp;
    logic [FC-1:0]  nf_clamp;
    t_cmd           cmd;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign nm_clamp = (int'(i_moving_count) > MAX_MOVING) ? MC'(MAX_MOVING)
                                                          : MC'(i_moving_count);
    assign nf_clamp = (int'(i_fixed_count) > MAX_FIXED) ? FC'(MAX_FIXED)
                                                        : FC'(i_fixed_count);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_jm    = r_jm;
        n_jf    = r_jf;
        n_nm    = r_nm;
        n_nf    = r_nf;
        n_pair  = r_pair;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.wr_moving = (i_action == ACT_LOAD_MOVING);
                    cmd.wr_fixed  = (i_action == ACT_LOAD_FIXED);
                    if ((i_action == ACT_COMPUTE) && (nm_clamp != '0)) begin
                        cmd.start = 1'b1;
                        n_nm      = nm_clamp;
                        n_nf      = nf_clamp;
                        n_i       = '0;
                        n_state   = S_ROW;
                    end
                end
            end
            S_ROW: begin
                if (r_i == r_nm) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else if (!i_sts.men_i) begin
                    n_i = r_i + MC'(1);
                end else begin
                    cmd.rd_row = 1'b1;
                    n_state    = S_ROW_LD;
                end
            end
            S_ROW_LD: begin
                cmd.ld_row = 1'b1;
                n_jf       = '0;
                n_state    = S_FIX;
            end
            S_FIX: begin
                if (r_jf == r_nf) begin
                    n_jm    = r_i + MC'(1);
                    n_state = S_MOV;
                end else if (!i_sts.fen_j) begin
                    n_jf = r_jf + FC'(1);
                end else begin
                    cmd.rd_fix = 1'b1;
                    n_state    = S_FIX_LD;
                end
            end
            S_FIX_LD: begin
                cmd.ld_fix = 1'b1;
                n_pair     = 1'b0;
                n_state    = S_P_DIFF;
            end
            S_MOV: begin
                if (r_jm == r_nm) begin
                    n_state = S_ROW_END;
                end else if (!i_sts.men_j) begin
                    n_jm = r_jm + MC'(1);
                end else begin
                    cmd.rd_mov = 1'b1;
                    n_state    = S_MOV_LD;
                end
            end
            S_MOV_LD: begin
                cmd.ld_mov = 1'b1;
                n_pair     = 1'b1;
                n_state    = S_P_DIFF;
            end
            S_P_DIFF: begin
                cmd.p_diff = 1'b1;
                n_state    = S_P_SQ;
            end
            S_P_SQ: begin
                cmd.p_sq = 1'b1;
                n_state  = S_P_R2;
            end
            S_P_R2: begin
                cmd.p_r2 = 1'b1;
                n_state  = S_P_SEL;
            end
            S_P_SEL: begin
                if (i_sts.far) begin
                    cmd.div_far = 1'b1;
                    n_state     = S_P_DIV;
                end else begin
                    cmd.sqrt_init = 1'b1;
                    n_state       = S_P_SQRT;
                end
            end
            S_P_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (i_sts.sqrt_last) begin
                    n_state = S_P_NMUL;
                end
            end
            S_P_NMUL: begin
                cmd.near_mul = 1'b1;
                n_state      = S_P_NDIV;
            end
            S_P_NDIV: begin
                cmd.div_near = 1'b1;
                n_state      = S_P_DIV;
            end
            S_P_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_P_TLO;
                end
            end
            S_P_TLO: begin
                cmd.t_lo = 1'b1;
                n_state  = S_P_THI;
            end
            S_P_THI: begin
                cmd.t_hi = 1'b1;
                n_state  = S_P_TERM;
            end
            S_P_TERM: begin
                cmd.t_term = 1'b1;
                n_state    = S_P_ACC;
            end
            S_P_ACC: begin
                if (r_pair) begin
                    cmd.acc_pair = 1'b1;
                    n_jm         = r_jm + MC'(1);
                    n_state      = S_MOV;
                end else begin
                    cmd.acc_fix = 1'b1;
                    n_jf        = r_jf + FC'(1);
                    n_state     = S_FIX;
                end
            end
            S_ROW_END: begin
                cmd.row_wr = 1'b1;
                n_i        = r_i + MC'(1);
                n_state    = S_ROW;
            end
            S_OUT_RD: begin
                cmd.rd_out = 1'b1;
                n_state    = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = ((r_i + MC'(1)) == r_nm);
                    if (cmd.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + MC'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_jm    <= '0;
            r_jf    <= '0;
            r_nm    <= '0;
            r_nf    <= '0;
            r_pair  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_jm    <= n_jm;
            r_jf    <= n_jf;
            r_nm    <= n_nm;
            r_nf    <= n_nf;
            r_pair  <= n_pair;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cmd   = cmd;
    assign o_i     = r_i;
    assign o_jm    = r_jm;
    assign o_jf    = r_jf;
endmodule

// ===== rtl/core/sgfa_dp.sv =====
// sgfa_dp: body tables, force accumulators, pull arithmetic and result register
// depends on sgfa_pkg and sgfa_ram
module sgfa_dp #(
    parameter int MAX_MOVING  = 64,
    parameter int MAX_FIXED   = 16,
    parameter int FORCE_WIDTH = 48,
    localparam int MC = $clog2(MAX_MOVING + 1),
    localparam int FC = $clog2(MAX_FIXED + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgfa_pkg::t_cmd                i_cmd,
    output sgfa_pkg::t_sts                o_sts,
    input  logic [MC-1:0]                 i_i,
    input  logic [MC-1:0]                 i_jm,
    input  logic [FC-1:0]                 i_jf,
    input  logic [sgfa_pkg::GAIN_W-1:0]   i_gravity_gain,
    input  logic [sgfa_pkg::SLOT_W-1:0]   i_slot,
    input  logic signed [sgfa_pkg::POS_W-1:0] i_body_x,
    input  logic signed [sgfa_pkg::POS_W-1:0] i_body_y,
    input  logic [sgfa_pkg::MASS_W-1:0]   i_mass,
    input  logic                          i_enabled,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [sgfa_pkg::IDX_W-1:0]    o_body_index,
    output logic signed [FORCE_WIDTH-1:0] o_force_x,
    output logic signed [FORCE_WIDTH-1:0] o_force_y,
    output logic                          o_last
);
    import sgfa_pkg::*;

    localparam int FW = FORCE_WIDTH;
    localparam int MA = $clog2(MAX_MOVING);
    localparam int FA = (MAX_FIXED > 1) ? $clog2(MAX_FIXED) : 1;
    localparam int BW = 2 * POS_W + MASS_W;
    localparam int AW = 2 * FW;
    localparam logic signed [FW-1:0] FMAX = {1'b0, {(FW - 1){1'b1}}};
    localparam logic signed [FW-1:0] FMIN = {1'b1, {(FW - 1){1'b0}}};

    function automatic logic signed [FW-1:0] sat_add(input logic signed [FW-1:0] a,
                                                     input logic signed [FW:0] b);
        logic signed [FW+1:0] s;
        s = (FW + 2)'(a) + (FW + 2)'(b);
        if (s[FW+1:FW-1] == {3{s[FW+1]}}) begin
            sat_add = s[FW-1:0];
        end else begin
            sat_add = s[FW+1] ? FMIN : FMAX;
        end
    endfunction

    // c * |d| / 256, saturated, with the sign of d (truncates toward zero)
    function automatic logic signed [FW-1:0] make_term(input logic [PP_W-1:0] pl,
                                                       input logic [PP_W-1:0] ph,
                                                       input logic neg);
        logic [PROD_W-1:0] p;
        logic [63:0]       m;
        logic              sat;
        logic [FW-1:0]     mv;
        p   = PROD_W'(pl) + (PROD_W'(ph) << QH_W);
        m   = 64'(p[PROD_W-1:8]);
        sat = |m[63:FW-1];
        mv  = m[FW-1:0];
        if (sat) begin
            make_term = neg ? FMIN : FMAX;
        end else begin
            make_term = neg ? -mv : mv;
        end
    endfunction

    // tables
    logic [MAX_MOVING-1:0] r_men;
    logic [MAX_FIXED-1:0]  r_fen;
    logic [MAX_MOVING-1:0] r_acc_vld;
    logic                  r_acc_rv;
    logic [BW-1:0]         mov_rd, fix_rd, body_wr;
    logic [AW-1:0]         acc_rd, acc_wr;
    logic [MA-1:0]         mov_rd_addr, acc_rd_addr, acc_wr_addr, ld_m_addr;
    logic [FA-1:0]         ld_f_addr;
    logic                  ld_m_ok, ld_f_ok, acc_rd_en, acc_wr_en;
    logic signed [FW-1:0]  acc_rx, acc_ry;

    // operands
    logic signed [POS_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic [MASS_W-1:0]       r_am, r_bm;
    logic signed [FW-1:0]    r_acc_ix, r_acc_iy, r_acc_jx, r_acc_jy;

    // pull arithmetic
    logic signed [MAG_W-1:0] dx, dy;
    logic [MAG_W-1:0]        r_adx, r_ady;
    logic                    r_nx, r_ny;
    logic [GM1_W-1:0]        r_gm1;
    logic [GMM_W-1:0]        r_gmm;
    logic [SQ2_W-1:0]        r_x2, r_y2;
    logic [R2_W-1:0]         r_r2;
    logic [SQV_W-1:0]        r_sq_v, r_sq_bit;
    logic [SQV_W-1:0]        r_sq_res;
    logic [SQR_W-1:0]        sq_sum;
    logic [NUM_W-1:0]        r_div_n;
    logic [R2_W-1:0]         r_div_d, r_rem;
    logic [R2_W:0]           rem_sh;
    logic                    div_ge;
    logic [Q_W-1:0]          r_q;
    logic [DCNT_W-1:0]       r_dcnt;
    logic [PP_W-1:0]         r_plx, r_ply, r_phx, r_phy;
    logic signed [FW-1:0]    r_tx, r_ty;
    logic signed [FW:0]      ntx, nty;
    logic signed [FW-1:0]    jx_new, jy_new;

    // result register
    logic                    r_out_valid;
    logic [IDX_W-1:0]        r_out_idx;
    logic signed [FW-1:0]    r_out_fx, r_out_fy;
    logic                    r_out_last;

    // table writes from load requests
    assign ld_m_ok   = i_cmd.wr_moving && (int'(i_slot) < MAX_MOVING);
    assign ld_f_ok   = i_cmd.wr_fixed && (int'(i_slot) < MAX_FIXED);
    assign ld_m_addr = MA'(i_slot);
    assign ld_f_addr = FA'(i_slot);
    assign body_wr   = {i_body_x, i_body_y, i_mass};

    assign mov_rd_addr = i_cmd.rd_mov ? i_jm[MA-1:0] : i_i[MA-1:0];
    assign acc_rd_addr = i_cmd.rd_mov ? i_jm[MA-1:0] : i_i[MA-1:0];
    assign acc_rd_en   = i_cmd.rd_row || i_cmd.rd_mov || i_cmd.rd_out;
    assign acc_wr_en   = i_cmd.row_wr || i_cmd.acc_pair;
    assign acc_wr_addr = i_cmd.row_wr ? i_i[MA-1:0] : i_jm[MA-1:0];
    assign acc_wr      = i_cmd.row_wr ? {r_acc_ix, r_acc_iy} : {jx_new, jy_new};

    sgfa_ram #(.WIDTH(BW), .DEPTH(MAX_MOVING)) u_mov_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ld_m_ok),
        .i_wr_addr (ld_m_addr),
        .i_wr_data (body_wr),
        .i_rd_en   (i_cmd.rd_row || i_cmd.rd_mov),
        .i_rd_addr (mov_rd_addr),
        .o_rd_data (mov_rd)
    );

    sgfa_ram #(.WIDTH(BW), .DEPTH(MAX_FIXED)) u_fix_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ld_f_ok),
        .i_wr_addr (ld_f_addr),
        .i_wr_data (body_wr),
        .i_rd_en   (i_cmd.rd_fix),
        .i_rd_addr (i_jf[FA-1:0]),
        .o_rd_data (fix_rd)
    );

    sgfa_ram #(.WIDTH(AW), .DEPTH(MAX_MOVING)) u_acc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (acc_wr_en),
        .i_wr_addr (acc_wr_addr),
        .i_wr_data (acc_wr),
        .i_rd_en   (acc_rd_en),
        .i_rd_addr (acc_rd_addr),
        .o_rd_data (acc_rd)
    );

    // an accumulator not written since the compute started reads as zero
    assign acc_rx = r_acc_rv ? acc_rd[AW-1:FW] : '0;
    assign acc_ry = r_acc_rv ? acc_rd[FW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_men       <= '0;
            r_fen       <= '0;
            r_acc_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld_m_ok) begin
                r_men[ld_m_addr] <= i_enabled;
            end
            if (ld_f_ok) begin
                r_fen[ld_f_addr] <= i_enabled;
            end
            if (i_cmd.start) begin
                r_acc_vld <= '0;
            end else if (acc_wr_en) begin
                r_acc_vld[acc_wr_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // differences and sign-magnitude split
    assign dx = MAG_W'(r_bx) - MAG_W'(r_ax);
    assign dy = MAG_W'(r_by) - MAG_W'(r_ay);

    // integer square root step, two bits of r2 per cycle
    assign sq_sum = SQR_W'(r_sq_res) + SQR_W'(r_sq_bit);

    // restoring divider step, one quotient bit per cycle
    assign rem_sh = {r_rem, r_div_n[NUM_W-1]};
    assign div_ge = (rem_sh >= {1'b0, r_div_d});

    assign ntx    = -((FW + 1)'(r_tx));
    assign nty    = -((FW + 1)'(r_ty));
    assign jx_new = sat_add(r_acc_jx, ntx);
    assign jy_new = sat_add(r_acc_jy, nty);

    always_ff @(posedge i_clk) begin
        if (acc_rd_en) begin
            r_acc_rv <= r_acc_vld[acc_rd_addr];
        end
        if (i_cmd.ld_row) begin
            r_ax     <= mov_rd[BW-1 -: POS_W];
            r_ay     <= mov_rd[MASS_W +: POS_W];
            r_am     <= mov_rd[MASS_W-1:0];
            r_acc_ix <= acc_rx;
            r_acc_iy <= acc_ry;
        end
        if (i_cmd.ld_fix) begin
            r_bx <= fix_rd[BW-1 -: POS_W];
            r_by <= fix_rd[MASS_W +: POS_W];
            r_bm <= fix_rd[MASS_W-1:0];
        end
        if (i_cmd.ld_mov) begin
            r_bx     <= mov_rd[BW-1 -: POS_W];
            r_by     <= mov_rd[MASS_W +: POS_W];
            r_bm     <= mov_rd[MASS_W-1:0];
            r_acc_jx <= acc_rx;
            r_acc_jy <= acc_ry;
        end
        if (i_cmd.p_diff) begin
            r_adx <= dx[MAG_W-1] ? -dx : dx;
            r_ady <= dy[MAG_W-1] ? -dy : dy;
            r_nx  <= dx[MAG_W-1];
            r_ny  <= dy[MAG_W-1];
            r_gm1 <= i_gravity_gain * r_am;
        end
        if (i_cmd.p_sq) begin
            r_x2  <= r_adx * r_adx;
            r_y2  <= r_ady * r_ady;
            r_gmm <= r_gm1 * r_bm;
        end
        if (i_cmd.p_r2) begin
            r_r2 <= r_x2 + r_y2;
        end
        if (i_cmd.sqrt_init) begin
            r_sq_v   <= r_r2[SQV_W-1:0];
            r_sq_res <= '0;
            r_sq_bit <= SQ_BIT_INIT;
        end
        if (i_cmd.sqrt_step) begin
            if (SQR_W'(r_sq_v) >= sq_sum) begin
                r_sq_v   <= SQV_W'(SQR_W'(r_sq_v) - sq_sum);
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
        end
        if (i_cmd.near_mul) begin
            r_div_n <= NUM_W'(r_gmm * r_sq_res[SQS_W-1:0]);
        end
        if (i_cmd.div_far) begin
            r_div_n <= {r_gmm, 16'd0};
            r_div_d <= r_r2;
        end
        if (i_cmd.div_near) begin
            r_div_d <= SOFT_DIV;
        end
        if (i_cmd.div_far || i_cmd.div_near) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= div_ge ? R2_W'(rem_sh - {1'b0, r_div_d}) : rem_sh[R2_W-1:0];
            r_div_n <= r_div_n << 1;
            r_q     <= {r_q[Q_W-2:0], div_ge};
            r_dcnt  <= r_dcnt + DCNT_W'(1);
        end
        if (i_cmd.t_lo) begin
            r_plx <= r_q[QH_W-1:0] * r_adx;
            r_ply <= r_q[QH_W-1:0] * r_ady;
        end
        if (i_cmd.t_hi) begin
            r_phx <= r_q[Q_W-1:QH_W] * r_adx;
            r_phy <= r_q[Q_W-1:QH_W] * r_ady;
        end
        if (i_cmd.t_term) begin
            r_tx <= make_term(r_plx, r_phx, r_nx);
            r_ty <= make_term(r_ply, r_phy, r_ny);
        end
        if (i_cmd.acc_fix || i_cmd.acc_pair) begin
            r_acc_ix <= sat_add(r_acc_ix, (FW + 1)'(r_tx));
            r_acc_iy <= sat_add(r_acc_iy, (FW + 1)'(r_ty));
        end
        if (i_cmd.out_load) begin
            r_out_idx  <= IDX_W'(i_i);
            r_out_fx   <= acc_rx;
            r_out_fy   <= acc_ry;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.men_i     = r_men[i_i[MA-1:0]];
    assign o_sts.men_j     = r_men[i_jm[MA-1:0]];
    assign o_sts.fen_j     = r_fen[i_jf[FA-1:0]];
    assign o_sts.far       = (r_r2 >= SOFT_R2);
    assign o_sts.sqrt_last = r_sq_bit[0];
    assign o_sts.div_last  = (r_dcnt == DCNT_LAST);
    assign o_sts.out_free  = !r_out_valid || !i_stall;

    assign o_valid      = r_out_valid;
    assign o_body_index = r_out_idx;
    assign o_force_x    = r_out_fx;
    assign o_force_y    = r_out_fy;
    assign o_last       = r_out_last;
endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for softened_gravity_force_accumulator with a
// directed table, random load/compute phases and a built-in force predictor
// depends on sgfa_pkg and the block's RTL
module testbench;
    import sgfa_pkg::*;

    localparam int NMOV     = 64;
    localparam int NFIX     = 16;
    localparam int FW       = 48;
    localparam longint FMAX = (64'sd1 <<< (FW - 1)) - 1;
    localparam longint FMIN = -FMAX - 1;
    localparam int WDOG_LIMIT  = 1500000;
    localparam int QUIET_TICKS = 40;
    localparam logic [ACT_W-1:0] ACT_UNKNOWN = 2'd3;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // one directed row: a request or a register write; zero_exp means every
    // result of this compute must carry zero force, typed in rather than predicted
    typedef struct {
        t_row_kind          kind;
        logic [ACT_W-1:0]   act;
        int                 slot;
        int                 px;
        int                 py;
        int                 mass;
        bit                 en;
        logic [CFG_IDX_W-1:0] reg_idx;
        int                 reg_val;
        bit                 zero_exp;
    } t_row;

    typedef struct {
        logic [IDX_W-1:0]     idx;
        logic signed [FW-1:0] fx;
        logic signed [FW-1:0] fy;
        logic                 last;
    } t_force;

    logic                      i_clk, i_rst_n;
    logic                      i_valid, o_stall;
    logic [ACT_W-1:0]          i_action;
    logic [SLOT_W-1:0]         i_slot;
    logic signed [POS_W-1:0]   i_body_x, i_body_y;
    logic [MASS_W-1:0]         i_mass;
    logic                      i_enabled;
    logic                      o_valid, i_stall;
    logic [IDX_W-1:0]          o_body_index;
    logic signed [FW-1:0]      o_force_x, o_force_y;
    logic                      o_last;
    logic                      i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DAT_W-1:0]      i_cfg_data;

    softened_gravity_force_accumulator #(
        .MAX_MOVING(NMOV), .MAX_FIXED(NFIX), .FORCE_WIDTH(FW)
    ) dut (.*);

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // mirror of the body tables and registers
    logic [GAIN_W-1:0] gain_q;
    logic [MCNT_W-1:0] mcnt_q;
    logic [FCNT_W-1:0] fcnt_q;
    longint            mov_px[NMOV], mov_py[NMOV], fix_px[NFIX], fix_py[NFIX];
    int unsigned       mov_m[NMOV], fix_m[NFIX];
    bit                mov_en[NMOV], fix_en[NFIX];

    t_force forces_due[$];
    int     errors;
    int     n_items, n_forces, n_computes, n_cfg;
    bit     idle_en;
    int     wdog;

    // integer square root, argument below 100 in Q.16 so the root is under 4096
    function automatic longint isqrt_near(longint v);
        longint s;
        s = 0;
        for (int b = 11; b >= 0; b--) begin
            if ((s | (64'd1 << b)) * (s | (64'd1 << b)) <= v)
                s = s | (64'd1 << b);
        end
        return s;
    endfunction

    // one axis of the pull: c*|d| in Q.16, truncated toward zero, saturated
    function automatic longint pull_axis(logic [127:0] c, longint d);
        logic [127:0] p;
        longint       ad;
        ad = (d < 0) ? -d : d;
        p  = (c * 128'(ad)) >> 8;
        if (p > FMAX)
            return (d < 0) ? FMIN : FMAX;
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [127:0] pull_coeff(longint dx, longint dy,
                                                 int unsigned ma, int unsigned mb);
        logic [127:0] r2, gmm;
        r2  = dx * dx + dy * dy;
        gmm = 128'(gain_q) * ma * mb;
        // far zone: inverse square; near zone: grows with distance, zero when coincident
        if (r2 >= 128'd6553600)
            return (gmm << 16) / r2;
        return gmm * isqrt_near(longint'(r2)) / 128'd256000;
    endfunction

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (s > FMAX) return FMAX;
        if (s < FMIN) return FMIN;
        return s;
    endfunction

    // direct-sum forces of one compute request, queued in slot order
    function automatic void predict_forces(bit zero_only);
        longint ax[NMOV], ay[NMOV];
        logic [127:0] c;
        longint fx, fy, dx, dy;
        int nm, nf;
        t_force r;
        nm = (mcnt_q > NMOV) ? NMOV : mcnt_q;
        nf = (fcnt_q > NFIX) ? NFIX : fcnt_q;
        foreach (ax[k]) begin
            ax[k] = 0;
            ay[k] = 0;
        end
        for (int i = 0; i < nm && !zero_only; i++) begin
            if (!mov_en[i]) continue;
            for (int j = 0; j < nf; j++) begin
                if (!fix_en[j]) continue;
                dx = fix_px[j] - mov_px[i];
                dy = fix_py[j] - mov_py[i];
                c  = pull_coeff(dx, dy, mov_m[i], fix_m[j]);
                ax[i] = sat_sum(ax[i], pull_axis(c, dx));
                ay[i] = sat_sum(ay[i], pull_axis(c, dy));
            end
            // pairs: lower slot gains the pull, higher slot the opposite
            for (int j = i + 1; j < nm; j++) begin
                if (!mov_en[j]) continue;
                dx = mov_px[j] - mov_px[i];
                dy = mov_py[j] - mov_py[i];
                c  = pull_coeff(dx, dy, mov_m[i], mov_m[j]);
                fx = pull_axis(c, dx);
                fy = pull_axis(c, dy);
                ax[i] = sat_sum(ax[i], fx);
                ay[i] = sat_sum(ay[i], fy);
                ax[j] = sat_sum(ax[j], -fx);
                ay[j] = sat_sum(ay[j], -fy);
            end
        end
        for (int i = 0; i < nm; i++) begin
            r.idx  = IDX_W'(i);
            r.fx   = FW'(ax[i]);
            r.fy   = FW'(ay[i]);
            r.last = (i == nm - 1);
            forces_due.push_back(r);
        end
    endfunction

    // apply an accepted request to the mirror tables
    function automatic void absorb_request(logic [ACT_W-1:0] a, int s, int x, int y,
                                           int m, bit en, bit zero_only);
        logic signed [POS_W-1:0] sx, sy;
        sx = POS_W'(x);
        sy = POS_W'(y);
        if (a == ACT_LOAD_MOVING) begin
            mov_px[s] = sx; mov_py[s] = sy; mov_m[s] = m[15:0]; mov_en[s] = en;
            n_items++;
        end else if (a == ACT_LOAD_FIXED) begin
            // slots past the fixed table are dropped by the block
            if (s < NFIX) begin
                fix_px[s] = sx; fix_py[s] = sy; fix_m[s] = m[15:0]; fix_en[s] = en;
            end
            n_items++;
        end else if (a == ACT_COMPUTE) begin
            predict_forces(zero_only);
            n_computes++;
            n_items++;
        end
    endfunction

    // one request, with an optional random hold-off before it
    task automatic send_request(logic [ACT_W-1:0] a, int s, int x, int y, int m,
                                bit en, bit zero_only);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= a;
        i_slot    <= SLOT_W'(s);
        i_body_x  <= POS_W'(x);
        i_body_y  <= POS_W'(y);
        i_mass    <= MASS_W'(m);
        i_enabled <= en;
        do @(posedge i_clk); while (o_stall);
        absorb_request(a, s, x, y, m, en, zero_only);
    endtask

    // block must be idle: every force back, then a margin for work with no result
    task automatic wait_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (forces_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] r, int v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= r;
        i_cfg_data  <= CFG_DAT_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (r)
            CFG_GRAVITY_GAIN: gain_q = GAIN_W'(v);
            CFG_MOVING_COUNT: mcnt_q = MCNT_W'(v);
            CFG_FIXED_COUNT:  fcnt_q = FCNT_W'(v);
            default: ;
        endcase
        n_cfg++;
    endtask

    // result side: random stall bursts, then none late in the run
    int stall_left;
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_en && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        i_stall <= (stall_left > 0);
    end

    // compare each accepted force against the oldest one due
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (forces_due.size() == 0) begin
                $display("%0t: unexpected result slot %0d fx %0d fy %0d", $time,
                         o_body_index, o_force_x, o_force_y);
                errors++;
            end else begin
                e = forces_due.pop_front();
                n_forces++;
                if (o_body_index !== e.idx) begin
                    $display("%0t: body_index expected %0d actual %0d", $time,
                             e.idx, o_body_index);
                    errors++;
                end
                if (o_force_x !== e.fx) begin
                    $display("%0t: force_x slot %0d expected %0d actual %0d", $time,
                             e.idx, e.fx, o_force_x);
                    errors++;
                end
                if (o_force_y !== e.fy) begin
                    $display("%0t: force_y slot %0d expected %0d actual %0d", $time,
                             e.idx, e.fy, o_force_y);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $display("%0t: last slot %0d expected %0b actual %0b", $time,
                             e.idx, e.last, o_last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results still due", $time,
                     forces_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // directed table: reset behavior, extremes, zero-force cases, dropped requests
    t_row steps[] = '{
        // compute right after reset, count zero: nothing comes back
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 1},
        '{ROW_REQ, ACT_LOAD_MOVING, 0,        0,        0,   256, 1, 0, 0, 0},
        '{ROW_REQ, ACT_LOAD_MOVING, 1,        0,        0, 65535, 1, 0, 0, 0},
        '{ROW_CFG, ACT_COMPUTE,     0,        0,        0,     0, 0, CFG_MOVING_COUNT, 2, 0},
        // coincident bodies pull with zero force
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 1},
        '{ROW_REQ, ACT_LOAD_MOVING, 1,  8388607, -8388608, 65535, 0, 0, 0, 0},
        // one body active, the other disabled: both zero
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 1},
        '{ROW_REQ, ACT_LOAD_MOVING, 1,  8388607, -8388608, 65535, 1, 0, 0, 0},
        '{ROW_REQ, ACT_LOAD_MOVING, 0, -8388608,  8388607, 65535, 1, 0, 0, 0},
        '{ROW_CFG, ACT_COMPUTE,     0,        0,        0,     0, 0, CFG_GRAVITY_GAIN, 65535, 0},
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 0},
        '{ROW_REQ, ACT_LOAD_FIXED,  0,      100,      -50, 65535, 1, 0, 0, 0},
        // fixed slot past the table and an unknown action are both dropped
        '{ROW_REQ, ACT_LOAD_FIXED, 40,     5000,     5000, 65535, 1, 0, 0, 0},
        '{ROW_REQ, ACT_UNKNOWN,     5,        1,        1,     1, 1, 0, 0, 0},
        '{ROW_CFG, ACT_COMPUTE,     0,        0,        0,     0, 0, CFG_FIXED_COUNT, 1, 0},
        '{ROW_REQ, ACT_LOAD_MOVING, 0,        0,        0, 65535, 1, 0, 0, 0},
        '{ROW_REQ, ACT_LOAD_MOVING, 1,      256,        0, 65535, 1, 0, 0, 0},
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 0},
        // zero gain: every force vanishes
        '{ROW_CFG, ACT_COMPUTE,     0,        0,        0,     0, 0, CFG_GRAVITY_GAIN, 0, 0},
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 1},
        '{ROW_CFG, ACT_COMPUTE,     0,        0,        0,     0, 0, CFG_GRAVITY_GAIN, 10, 0},
        '{ROW_REQ, ACT_COMPUTE,     0,        0,        0,     0, 0, 0, 0, 0}
    };

    function automatic int pick_pos(bit clustered);
        if (clustered)
            return $urandom_range(0, 6000) - 3000;
        return int'($urandom);
    endfunction

    function automatic int pick_mass();
        case ($urandom_range(0, 5))
            0: return 65535;
            1: return 0;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        int nm, nf, nloads, s, a, phase;
        bit clustered, big;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACT_LOAD_MOVING;
        i_slot      <= '0;
        i_body_x    <= '0;
        i_body_y    <= '0;
        i_mass      <= '0;
        i_enabled   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GRAVITY_GAIN;
        i_cfg_data  <= '0;
        n_items = 0; n_computes = 0; n_cfg = 0;
        idle_en     = 1'b1;
        gain_q = 10; mcnt_q = 0; fcnt_q = 0;
        foreach (mov_en[k]) mov_en[k] = 0;
        foreach (fix_en[k]) fix_en[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[k]) begin
            if (steps[k].kind == ROW_CFG) begin
                wait_quiet();
                write_reg(steps[k].reg_idx, steps[k].reg_val);
            end else begin
                send_request(steps[k].act, steps[k].slot, steps[k].px, steps[k].py,
                             steps[k].mass, steps[k].en, steps[k].zero_exp);
            end
        end

        // random phases: program registers, load bodies, compute; the first one
        // fills both tables with counts past their depth
        phase = 0;
        while (n_items < 300) begin
            big     = (phase == 0);
            idle_en = (n_items < 250);
            // every phase waits for all forces before touching registers
            wait_quiet();
            if (big) begin
                nm = 127;
                nf = 31;
            end else begin
                nm = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                nf = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(0, 4);
            end
            case ($urandom_range(0, 4))
                0: write_reg(CFG_GRAVITY_GAIN, 65535);
                1: write_reg(CFG_GRAVITY_GAIN, 1);
                default: write_reg(CFG_GRAVITY_GAIN, $urandom_range(0, 65535));
            endcase
            write_reg(CFG_MOVING_COUNT, nm);
            write_reg(CFG_FIXED_COUNT, nf);
            clustered = ($urandom_range(0, 1) == 0);
            if (big) begin
                for (int k = 0; k < NMOV; k++)
                    send_request(ACT_LOAD_MOVING, k, pick_pos(clustered),
                                 pick_pos(clustered), pick_mass(), 1'b1, 1'b0);
                for (int k = 0; k < NFIX; k++)
                    send_request(ACT_LOAD_FIXED, k, pick_pos(clustered),
                                 pick_pos(clustered), pick_mass(), 1'b1, 1'b0);
            end else begin
                nloads = nm + nf + $urandom_range(0, 3);
                for (int k = 0; k < nloads; k++) begin
                    a = ($urandom_range(0, 11) == 0) ? int'(ACT_UNKNOWN) :
                        (($urandom_range(0, nm + nf) < nm) ? ACT_LOAD_MOVING
                                                            : ACT_LOAD_FIXED);
                    if ($urandom_range(0, 7) == 0)
                        s = $urandom_range(0, 63);
                    else if (a == ACT_LOAD_MOVING)
                        s = $urandom_range(0, (nm > 0) ? nm - 1 : 0);
                    else
                        s = $urandom_range(0, (nf > 0) ? nf - 1 : 0);
                    send_request(ACT_W'(a), s, pick_pos(clustered),
                                 pick_pos(clustered), pick_mass(),
                                 ($urandom_range(0, 3) != 0), 1'b0);
                end
            end
            send_request(ACT_COMPUTE, $urandom_range(0, 63), int'($urandom),
                         int'($urandom), $urandom_range(0, 65535),
                         $urandom_range(0, 1), 1'b0);
            phase++;
        end

        wait_quiet();
        $display("ran %0d requests in %0d computes and %0d register writes;",
                 n_items, n_computes, n_cfg);
        $display("checked %0d force results, %0d mismatches", n_forces, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sgfa_pkg.sv
rtl/core/sgfa_ram.sv
rtl/core/sgfa_ctrl.sv
rtl/core/sgfa_dp.sv
rtl/core/softened_gravity_force_accumulator.sv
dv/testbench.sv
